// ===== design/kvsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kvsp_pkg;

	localparam int BUFFER_BYTES_DEF = 128;

	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_COLON  = 8'h3A;
	localparam logic [7:0] CHAR_COMMA  = 8'h2C;

	localparam int VALUE_W    = 32;
	localparam int KEY_COUNT  = 3;
	localparam int OUT_DATA_W = 104;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_packet;
	} byte_beat_t;

	typedef struct packed {
		logic [KEY_COUNT-1:0] seen;
		logic [VALUE_W-1:0]   net_rate;
		logic [VALUE_W-1:0]   ram_load;
		logic [VALUE_W-1:0]   cpu_load;
	} results_t;

endpackage

`default_nettype wire

// ===== design/key_value_status_packet_parser.sv =====
// Key/value status packet parser.
// Input stream: one packet byte per beat on s_tdata, s_tlast marking the final
// byte of a packet. A leading '$' is dropped, at most BUFFER_BYTES-1 bytes of a
// packet are parsed, and a zero byte ends the content. Comma separated tokens
// with key CPU, RAM or NET update a stored, saturated signed 32-bit value.
// Output stream: one beat per packet, issued for the beat that carries
// s_tlast, holding the three stored values and their seen flags. Values and
// flags persist from packet to packet.
// Path: the input register takes the final beat when it is accepted, and the
// result register loads from it when that beat is processed; a pending
// result can hold the beat in the input register in between.
// Throughput: one byte per cycle while no final beat waits on a result; the
// parse update is a single pass of logic from input register to parser state.
// Reset: arst_n clears all parser state, the stored values and the flags.
// Stall: while a result waits on m_tready, input beats that do not end a
// packet keep flowing; a second final beat holds in the input register, and
// s_tready falls only then.
`timescale 1ns / 1ps
`default_nettype none

module key_value_status_packet_parser #(
	parameter int BUFFER_BYTES = kvsp_pkg::BUFFER_BYTES_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	input  wire  [7:0]                        s_tdata,  // char_byte
	input  wire                               s_tlast,  // end_of_packet
	output logic                              m_tvalid,
	input  wire                               m_tready,
	// cpu_load, ram_load, net_rate, cpu_seen, ram_seen, net_seen, zero pad
	output logic [kvsp_pkg::OUT_DATA_W-1:0]   m_tdata
);

	logic                  s1_valid_q;
	kvsp_pkg::byte_beat_t  beat_s1;
	logic                  advance;
	kvsp_pkg::results_t    snap;
	kvsp_pkg::results_t    result_q;

	assign advance  = s1_valid_q && (!beat_s1.end_of_packet || !m_tvalid || m_tready);
	assign s_tready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			beat_s1.char_byte     <= s_tdata;
			beat_s1.end_of_packet <= s_tlast;
		end
	end

	kvsp_byte_parser #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_parser (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (advance),
		.beat  (beat_s1),
		.snap  (snap)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance && beat_s1.end_of_packet) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && beat_s1.end_of_packet) begin
			result_q <= snap;
		end
	end

	assign m_tdata = {5'd0, result_q.seen[2], result_q.seen[1], result_q.seen[0],
		result_q.net_rate, result_q.ram_load, result_q.cpu_load};

	// A processed final beat always leaves a result in the output register.
	a_eop_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && beat_s1.end_of_packet |=> m_tvalid)
		else $error("final beat produced no result");

	// An accepted beat is held in the input register.
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> s1_valid_q)
		else $error("accepted beat lost");

	// A final beat blocked by a pending result keeps its byte.
	a_hold_eop: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && beat_s1.end_of_packet && m_tvalid && !m_tready
		|=> s1_valid_q && $stable(beat_s1))
		else $error("blocked final beat changed");

endmodule

`default_nettype wire

// ===== design/kvsp_byte_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kvsp_byte_parser #(
	parameter int BUFFER_BYTES = kvsp_pkg::BUFFER_BYTES_DEF
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       en,
	input  wire kvsp_pkg::byte_beat_t beat,
	output kvsp_pkg::results_t        snap
);

	localparam int POS_W = $clog2(BUFFER_BYTES);
	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(BUFFER_BYTES - 1);
	localparam logic [31:0] SAT_MAG = 32'h8000_0000;
	localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [2:0] CAND_ALL = 3'b111;
	localparam logic [2:0] KLEN_FULL = 3'd3;
	localparam logic [2:0] KLEN_OVER = 3'd4;
	localparam logic [23:0] KEY_CPU = {8'h55, 8'h50, 8'h43};
	localparam logic [23:0] KEY_RAM = {8'h4D, 8'h41, 8'h52};
	localparam logic [23:0] KEY_NET = {8'h54, 8'h45, 8'h4E};

	typedef enum logic [2:0] {
		PH_KEY,
		PH_SKIP,
		PH_WS,
		PH_DIG,
		PH_DONE
	} phase_t;

	logic [POS_W-1:0] pos_q, pos_n;
	logic             stopped_q, stopped_n;
	phase_t           phase_q, phase_n;
	logic [2:0]       klen_q, klen_n;
	logic [2:0]       cand_q, cand_n;
	logic [31:0]      acc_q, acc_n;
	logic             neg_q, neg_n;
	logic [31:0]      cpu_q, cpu_n;
	logic [31:0]      ram_q, ram_n;
	logic [31:0]      net_q, net_n;
	logic [2:0]       valid_q, valid_n;

	logic [7:0]  c;
	logic        is_digit;
	logic        is_space;
	logic [3:0]  digit;
	logic [35:0] acc_times10;
	logic        store_en;
	logic [31:0] store_val;
	logic [1:0]  kidx;

	function automatic logic [31:0] sat_value(input logic [31:0] a, input logic n);
		logic [31:0] m;
		begin
			if (n) begin
				m = (a > SAT_MAG) ? SAT_MAG : a;
				sat_value = 32'd0 - m;
			end else begin
				sat_value = (a > SAT_POS) ? SAT_POS : a;
			end
		end
	endfunction

	assign c        = beat.char_byte;
	assign is_digit = (c >= 8'h30) && (c <= 8'h39);
	assign is_space = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	assign digit    = c[3:0];
	assign acc_times10 = {acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {32'd0, digit};
	assign kidx     = klen_q[1:0];

	always_comb begin
		pos_n     = pos_q;
		stopped_n = stopped_q;
		phase_n   = phase_q;
		klen_n    = klen_q;
		cand_n    = cand_q;
		acc_n     = acc_q;
		neg_n     = neg_q;
		cpu_n     = cpu_q;
		ram_n     = ram_q;
		net_n     = net_q;
		valid_n   = valid_q;
		store_en  = 1'b0;

		if (en && !stopped_q && (pos_q < POS_LIMIT)) begin
			pos_n = pos_q + POS_W'(1);
			if (c == 8'h00) begin
				stopped_n = 1'b1;
			end else if (!((pos_q == '0) && (c == kvsp_pkg::CHAR_DOLLAR))) begin
				if (c == kvsp_pkg::CHAR_COMMA) begin
					phase_n = PH_KEY;
					klen_n  = 3'd0;
					cand_n  = CAND_ALL;
				end else begin
					unique case (phase_q)
						PH_KEY: begin
							if (c == kvsp_pkg::CHAR_COLON) begin
								if ((klen_q == KLEN_FULL) && (cand_q != 3'b000)) begin
									acc_n    = 32'd0;
									neg_n    = 1'b0;
									phase_n  = PH_WS;
									valid_n  = valid_q | cand_q;
									store_en = 1'b1;
								end else begin
									phase_n = PH_SKIP;
								end
							end else if (klen_q < KLEN_FULL) begin
								cand_n[0] = cand_q[0] && (KEY_CPU[kidx*8 +: 8] == c);
								cand_n[1] = cand_q[1] && (KEY_RAM[kidx*8 +: 8] == c);
								cand_n[2] = cand_q[2] && (KEY_NET[kidx*8 +: 8] == c);
								klen_n    = klen_q + 3'd1;
							end else begin
								klen_n = KLEN_OVER;
								cand_n = 3'b000;
							end
						end
						PH_WS: begin
							priority if (is_space) begin
								phase_n = PH_WS;
							end else if (c == 8'h2B) begin
								phase_n = PH_DIG;
							end else if (c == 8'h2D) begin
								neg_n    = 1'b1;
								phase_n  = PH_DIG;
								store_en = 1'b1;
							end else if (is_digit) begin
								phase_n  = PH_DIG;
								acc_n    = {28'd0, digit};
								store_en = 1'b1;
							end else begin
								phase_n = PH_DONE;
							end
						end
						PH_DIG: begin
							if (is_digit) begin
								acc_n    = (acc_times10 > {4'd0, SAT_MAG}) ? SAT_MAG
									: acc_times10[31:0];
								store_en = 1'b1;
							end else begin
								phase_n = PH_DONE;
							end
						end
						PH_SKIP, PH_DONE: begin
							phase_n = phase_q;
						end
						default: begin
							phase_n = phase_q;
						end
					endcase
				end
			end
		end

		store_val = sat_value(acc_n, neg_n);
		if (store_en) begin
			priority if (cand_n[0]) begin
				cpu_n = store_val;
			end else if (cand_n[1]) begin
				ram_n = store_val;
			end else if (cand_n[2]) begin
				net_n = store_val;
			end
		end
	end

	assign snap.cpu_load = cpu_n;
	assign snap.ram_load = ram_n;
	assign snap.net_rate = net_n;
	assign snap.seen     = valid_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			stopped_q <= 1'b0;
			phase_q   <= PH_KEY;
			klen_q    <= 3'd0;
			cand_q    <= CAND_ALL;
			acc_q     <= 32'd0;
			neg_q     <= 1'b0;
			cpu_q     <= 32'd0;
			ram_q     <= 32'd0;
			net_q     <= 32'd0;
			valid_q   <= 3'b000;
		end else if (en) begin
			cpu_q   <= cpu_n;
			ram_q   <= ram_n;
			net_q   <= net_n;
			valid_q <= valid_n;
			if (beat.end_of_packet) begin
				pos_q     <= '0;
				stopped_q <= 1'b0;
				phase_q   <= PH_KEY;
				klen_q    <= 3'd0;
				cand_q    <= CAND_ALL;
				acc_q     <= 32'd0;
				neg_q     <= 1'b0;
			end else begin
				pos_q     <= pos_n;
				stopped_q <= stopped_n;
				phase_q   <= phase_n;
				klen_q    <= klen_n;
				cand_q    <= cand_n;
				acc_q     <= acc_n;
				neg_q     <= neg_n;
			end
		end
	end

	// A seen flag is never cleared once it is set.
	a_seen_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((valid_q & $past(valid_q)) == $past(valid_q)))
		else $error("seen flag cleared");

	// The accumulator never grows past the saturation magnitude.
	a_acc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q <= SAT_MAG)
		else $error("accumulator out of range");

	// The key length resets to zero at the end of a packet.
	a_klen_eop: assert property (@(posedge clk) disable iff (!arst_n)
		en && beat.end_of_packet |=> (klen_q == 3'd0) && (cand_q == CAND_ALL))
		else $error("key state not cleared at end of packet");

endmodule

`default_nettype wire

// ===== bench/kvsp_status_checker.sv =====
`timescale 1ns / 1ps

module kvsp_status_checker (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_tvalid,
	input  wire                            s_tready,
	input  wire [7:0]                      s_tdata,  // char_byte
	input  wire                            s_tlast,  // end_of_packet
	input  wire                            m_tvalid,
	input  wire                            m_tready,
	// cpu_load, ram_load, net_rate, cpu_seen, ram_seen, net_seen, zero pad
	input  wire [kvsp_pkg::OUT_DATA_W-1:0] m_tdata,
	output int                             fail_count,
	output int                             reports_seen
);

	typedef enum logic [2:0] {
		SCAN_KEY,
		SCAN_SKIP,
		SCAN_SPACE,
		SCAN_DIGITS,
		SCAN_DONE
	} scan_phase_t;

	localparam logic [32:0] SAT_MAG    = 33'h0_8000_0000;
	localparam int          LAST_POS   = kvsp_pkg::BUFFER_BYTES_DEF - 1;
	localparam logic [7:0]  CHAR_PLUS  = "+";
	localparam logic [7:0]  CHAR_MINUS = "-";
	localparam logic [7:0]  CHAR_ZERO  = "0";
	localparam logic [7:0]  CHAR_NINE  = "9";
	localparam logic [7:0]  CHAR_SPACE = 8'h20;
	localparam logic [7:0]  CHAR_TAB   = 8'h09;
	localparam logic [7:0]  CHAR_CR    = 8'h0D;

	int                   byte_pos;
	logic                 stopped;
	scan_phase_t          phase;
	logic [2:0]           key_len;
	logic [2:0]           candidates;
	logic [32:0]          magnitude;
	logic                 negative;
	logic [31:0]          cpu_val;
	logic [31:0]          ram_val;
	logic [31:0]          net_val;
	logic [2:0]           seen_flags;
	kvsp_pkg::results_t   pending_reports[$];
	kvsp_pkg::results_t   snapshot;
	kvsp_pkg::results_t   want;

	function automatic logic [7:0] key_char(input int k, input int i);
		logic [23:0] word;
		case (k)
			0: word = "CPU";
			1: word = "RAM";
			default: word = "NET";
		endcase
		return word[23 - 8 * i -: 8];
	endfunction

	task restart_packet;
		byte_pos   = 0;
		stopped    = 1'b0;
		phase      = SCAN_KEY;
		key_len    = 3'd0;
		candidates = 3'b111;
		magnitude  = 33'd0;
		negative   = 1'b0;
	endtask

	task commit_value;
		logic [32:0] mag;
		logic [31:0] v;
		mag = magnitude;
		if (negative) begin
			if (mag > SAT_MAG)
				mag = SAT_MAG;
			v = -mag[31:0];
		end else begin
			if (mag > SAT_MAG - 33'd1)
				mag = SAT_MAG - 33'd1;
			v = mag[31:0];
		end
		if (candidates[0])
			cpu_val = v;
		else if (candidates[1])
			ram_val = v;
		else if (candidates[2])
			net_val = v;
	endtask

	task parse_char(input logic [7:0] c);
		logic [35:0] grown;
		logic        is_digit;
		is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
		if (c == kvsp_pkg::CHAR_COMMA) begin
			phase      = SCAN_KEY;
			key_len    = 3'd0;
			candidates = 3'b111;
		end else begin
			case (phase)
				SCAN_KEY: begin
					if (c == kvsp_pkg::CHAR_COLON) begin
						if (key_len == 3'd3 && candidates != 3'b000) begin
							magnitude  = 33'd0;
							negative   = 1'b0;
							phase      = SCAN_SPACE;
							seen_flags = seen_flags | candidates;
							commit_value();
						end else begin
							phase = SCAN_SKIP;
						end
					end else if (key_len < 3'd3) begin
						for (int k = 0; k < 3; k++)
							if (key_char(k, key_len) != c)
								candidates[k] = 1'b0;
						key_len = key_len + 3'd1;
					end else begin
						key_len    = 3'd4;
						candidates = 3'b000;
					end
				end
				SCAN_SPACE: begin
					if (c == CHAR_PLUS) begin
						phase = SCAN_DIGITS;
					end else if (c == CHAR_MINUS) begin
						negative = 1'b1;
						phase    = SCAN_DIGITS;
						commit_value();
					end else if (is_digit) begin
						phase     = SCAN_DIGITS;
						magnitude = c - CHAR_ZERO;
						commit_value();
					end else if (!(c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR))) begin
						phase = SCAN_DONE;
					end
				end
				SCAN_DIGITS: begin
					if (is_digit) begin
						grown = {3'b000, magnitude} * 36'd10 + (c - CHAR_ZERO);
						if (grown > SAT_MAG)
							magnitude = SAT_MAG;
						else
							magnitude = grown[32:0];
						commit_value();
					end else begin
						phase = SCAN_DONE;
					end
				end
				default: begin
				end
			endcase
		end
	endtask

	task report_mismatch(input string msg);
		$display("%0t ERROR %s", $time, msg);
		fail_count++;
	endtask

	task check_field(input string name, input logic [31:0] got, input logic [31:0] exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("%s: got %08h, expected %08h", name, got, exp_val));
	endtask

	initial begin
		fail_count   = 0;
		reports_seen = 0;
		cpu_val      = 32'd0;
		ram_val      = 32'd0;
		net_val      = 32'd0;
		seen_flags   = 3'b000;
		restart_packet();
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				reports_seen++;
				if (pending_reports.size() == 0) begin
					report_mismatch("status beat with no packet outstanding");
				end else begin
					want = pending_reports.pop_front();
					check_field("cpu_load", m_tdata[31:0], want.cpu_load);
					check_field("ram_load", m_tdata[63:32], want.ram_load);
					check_field("net_rate", m_tdata[95:64], want.net_rate);
					check_field("cpu_seen", m_tdata[96], want.seen[0]);
					check_field("ram_seen", m_tdata[97], want.seen[1]);
					check_field("net_seen", m_tdata[98], want.seen[2]);
				end
			end
			if (s_tvalid && s_tready) begin
				if (!stopped && byte_pos < LAST_POS) begin
					if (s_tdata == 8'h00)
						stopped = 1'b1;
					else if (!(byte_pos == 0 && s_tdata == kvsp_pkg::CHAR_DOLLAR))
						parse_char(s_tdata);
					byte_pos++;
				end
				if (s_tlast) begin
					snapshot.cpu_load = cpu_val;
					snapshot.ram_load = ram_val;
					snapshot.net_rate = net_val;
					snapshot.seen     = seen_flags;
					pending_reports.push_back(snapshot);
					restart_packet();
				end
			end
		end
	end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	typedef enum {
		KEY_INTACT,
		KEY_SHORT,
		KEY_LONG,
		KEY_SWAPPED,
		KEY_LOWERCASE
	} key_damage_t;

	localparam int         PHASE_BYTES = 430;
	localparam logic [7:0] CHAR_PLUS   = "+";
	localparam logic [7:0] CHAR_MINUS  = "-";
	localparam logic [7:0] CHAR_HASH   = "#";

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic [7:0] s_tdata  = 8'h00;
	logic       s_tlast  = 1'b0;
	logic       m_tready = 1'b0;

	wire                            s_tready;
	wire                            m_tvalid;
	wire [kvsp_pkg::OUT_DATA_W-1:0] m_tdata;

	int fail_count;
	int reports_seen;
	int packets_sent  = 0;
	int bytes_sent    = 0;
	int send_idle_pct = 0;
	int stall_pct     = 0;

	logic [7:0] pkt[$];

	key_value_status_packet_parser u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	kvsp_status_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.fail_count   (fail_count),
		.reports_seen (reports_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	initial begin
		#2_000_000;
		$display("FAIL key_value_status_packet_parser");
		$finish;
	end

	function automatic logic [7:0] pick_space();
		int r;
		r = $urandom_range(5);
		return (r == 5) ? 8'h20 : 8'(8'h09 + r);
	endfunction

	task send_beat(input logic [7:0] c, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task send_packet;
		for (int i = 0; i < pkt.size(); i++)
			send_beat(pkt[i], i == pkt.size() - 1);
		packets_sent++;
	endtask

	task drain_reports;
		s_tvalid <= 1'b0;
		while (reports_seen < packets_sent)
			@(posedge clk);
	endtask

	task add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			pkt.push_back(s[i]);
	endtask

	task add_field;
		logic [23:0] word;
		logic [7:0]  ch;
		key_damage_t damage;
		int          swap_pos;
		int          ndig;
		int          r;
		r = $urandom_range(99);
		if (r < 70) begin
			case ($urandom_range(2))
				0: word = "CPU";
				1: word = "RAM";
				default: word = "NET";
			endcase
			damage = KEY_INTACT;
			if ($urandom_range(99) < 15) begin
				case ($urandom_range(3))
					0: damage = KEY_SHORT;
					1: damage = KEY_LONG;
					2: damage = KEY_SWAPPED;
					default: damage = KEY_LOWERCASE;
				endcase
			end
			swap_pos = $urandom_range(2);
			for (int i = 0; i < 3; i++) begin
				ch = word[23 - 8 * i -: 8];
				if (damage == KEY_SWAPPED && i == swap_pos)
					ch = 8'($urandom_range(65, 90));
				if (damage == KEY_LOWERCASE && i == 0)
					ch = ch | 8'h20;
				if (!(damage == KEY_SHORT && i == 2))
					pkt.push_back(ch);
			end
			if (damage == KEY_LONG)
				pkt.push_back("U");
			pkt.push_back(kvsp_pkg::CHAR_COLON);
			if ($urandom_range(4) == 0)
				repeat ($urandom_range(1, 2)) pkt.push_back(pick_space());
			case ($urandom_range(3))
				0: pkt.push_back(CHAR_PLUS);
				1: pkt.push_back(CHAR_MINUS);
				default: begin
				end
			endcase
			ndig = ($urandom_range(9) < 7) ? $urandom_range(5) : $urandom_range(8, 12);
			repeat (ndig) pkt.push_back(8'($urandom_range(48, 57)));
			if ($urandom_range(4) == 0)
				pkt.push_back(8'($urandom_range(32, 126)));
		end else if (r < 80) begin
			repeat ($urandom_range(1, 5)) pkt.push_back(8'($urandom_range(65, 90)));
		end else if (r >= 88) begin
			repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom_range(32, 126)));
		end
	endtask

	task build_random_packet;
		logic oversized;
		int   nfields;
		int   t;
		pkt.delete();
		if ($urandom_range(99) < 8) begin
			repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom_range(255)));
		end else begin
			oversized = ($urandom_range(14) == 0);
			nfields   = $urandom_range(1, 5);
			if ($urandom_range(3) == 0)
				pkt.push_back(kvsp_pkg::CHAR_DOLLAR);
			t = 0;
			while (t < nfields || (oversized && pkt.size() < 150)) begin
				if (t > 0)
					pkt.push_back(kvsp_pkg::CHAR_COMMA);
				add_field();
				t++;
			end
			if ($urandom_range(4) == 0)
				pkt.push_back(CHAR_HASH);
			if ($urandom_range(9) == 0)
				pkt.insert($urandom_range(pkt.size()), 8'h00);
			if (pkt.size() == 0)
				pkt.push_back(kvsp_pkg::CHAR_COMMA);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		pkt.delete();
		add_text("$CPU:+7,RAM:");
		send_packet();
		pkt.delete();
		add_text("NET:-9999999999");
		send_packet();
		pkt.delete();
		pkt.push_back(8'hFF);
		send_packet();
		pkt.delete();
		pkt.push_back(8'h00);
		send_packet();
		drain_reports();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 58;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 58;
				end
				default: begin
					send_idle_pct = 37;
					stall_pct     = 37;
				end
			endcase
			while (bytes_sent < (p + 1) * PHASE_BYTES) begin
				build_random_packet();
				send_packet();
			end
			drain_reports();
		end

		repeat (10) @(posedge clk);
		$display("Sent %0d packets (%0d bytes) under four sender/receiver stall mixes;",
			packets_sent, bytes_sent);
		$display("%0d status beats were compared against the predicted values.", reports_seen);
		if (fail_count == 0)
			$display("PASS key_value_status_packet_parser");
		else
			$display("FAIL key_value_status_packet_parser");
		$finish;
	end

endmodule
